// File: hw/rtl/ssmc_pkg.sv
// Package for the streaming substring match collector: widths, field types,
// request and result codes, register indexes and the case-fold function.
// No dependencies; the rtl files that use it do so by scoped names, and the testbench imports it.
package ssmc_pkg;

   localparam int MAX_MATCHES = 256;
   localparam int QUERY_MAX   = 16;
   localparam int HIST_DEPTH  = 15;

   localparam int BYTE_W      = 8;
   localparam int REQ_W       = 3;
   localparam int KIND_W      = 2;
   localparam int LINE_W      = 16;
   localparam int COL_W       = 12;
   localparam int QLEN_W      = 5;
   localparam int NUM_W       = 8;
   localparam int TOTAL_W     = 9;
   localparam int ENTRY_W     = LINE_W + COL_W;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int QUERY_W     = 2 * CSR_DATA_W;

   localparam int IDX_W      = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
   localparam int CNT_W      = $clog2(MAX_MATCHES + 1);
   localparam int HIST_IW    = $clog2(HIST_DEPTH);

   localparam int COL_MAX    = (2 ** COL_W) - 1;
   localparam int LINE_MAX   = (2 ** LINE_W) - 1;

   typedef logic [BYTE_W-1:0]     byte_type;
   typedef logic [LINE_W-1:0]     line_type;
   typedef logic [COL_W-1:0]      col_type;
   typedef logic [COL_W:0]        col_ext_type;
   typedef logic [QLEN_W-1:0]     qlen_type;
   typedef logic [NUM_W-1:0]      num_type;
   typedef logic [TOTAL_W-1:0]    total_type;
   typedef logic [ENTRY_W-1:0]    entry_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [HIST_IW-1:0]    hist_idx_type;
   typedef logic [QUERY_W-1:0]    query_type;

   typedef enum logic [REQ_W-1:0] {
      REQ_TEXT   = 3'd0,
      REQ_EOL    = 3'd1,
      REQ_SEARCH = 3'd2,
      REQ_NEXT   = 3'd3,
      REQ_PREV   = 3'd4
   } req_kind_type;

   typedef enum logic [KIND_W-1:0] {
      RES_NEW  = 2'd0,
      RES_NAV  = 2'd1,
      RES_NONE = 2'd2
   } result_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_QUERY_LOW  = 2'd0,
      CSR_QUERY_HIGH = 2'd1,
      CSR_QUERY_LEN  = 2'd2,
      CSR_CASE_SENS  = 2'd3
   } csr_index_type;

   // History control from the top level to the matcher
   typedef struct packed {
      logic shift;
      logic clear;
   } hist_ctrl_type;

   // Fold ASCII upper case to lower case unless comparing exactly
   function automatic byte_type fold(input byte_type b, input logic exact);
      byte_type r;
      r = b;
      if (!exact && b >= 8'h41 && b <= 8'h5A) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/ssmc_stream_if.sv
// Valid/ready channel interfaces for the request and response streams.
// Depends on ssmc_pkg for the payload widths.
interface ssmc_req_if;
   logic                           valid;
   logic                           ready;
   logic [ssmc_pkg::REQ_W-1:0]     req_type;
   logic [ssmc_pkg::BYTE_W-1:0]    char_byte;

   modport source (output valid, req_type, char_byte, input ready);
   modport sink   (input valid, req_type, char_byte, output ready);
endinterface

interface ssmc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ssmc_pkg::KIND_W-1:0]    result_kind;
   logic [ssmc_pkg::LINE_W-1:0]    line_index;
   logic [ssmc_pkg::COL_W-1:0]     column;
   logic [ssmc_pkg::QLEN_W-1:0]    match_length;
   logic [ssmc_pkg::NUM_W-1:0]     match_number;
   logic [ssmc_pkg::TOTAL_W-1:0]   match_total;
   logic                           table_full;

   modport source (output valid, result_kind, line_index, column, match_length,
                   match_number, match_total, table_full, input ready);
   modport sink   (input valid, result_kind, line_index, column, match_length,
                   match_number, match_total, table_full, output ready);
endinterface

// File: hw/rtl/ssmc_ram.sv
// Generic single-write, single-read RAM with registered, enabled read data.
// No dependencies.
module ssmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic                                         re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // hold the read data until the next read
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: hw/rtl/ssmc_matcher.sv
// Byte history shift register and parallel per-character comparators.
// Depends on ssmc_pkg.
module ssmc_matcher (
   input  logic                    clock,
   input  logic                    reset,
   input  ssmc_pkg::hist_ctrl_type ctrl,
   input  ssmc_pkg::byte_type      char_byte,
   input  ssmc_pkg::query_type     query,
   input  ssmc_pkg::qlen_type      qlen,
   input  logic                    cmp_exact,
   output logic                    hit
);
   ssmc_pkg::byte_type hist_ff [ssmc_pkg::HIST_DEPTH];
   logic [ssmc_pkg::QUERY_MAX-1:0] lane_ok;

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         for (int i = 0; i < ssmc_pkg::HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (ctrl.shift) begin
         hist_ff[0] <= char_byte;
         for (int i = 1; i < ssmc_pkg::HIST_DEPTH; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

   // Lane k compares query character k with the byte qlen-1-k places back
   always_comb begin
      ssmc_pkg::byte_type   b;
      ssmc_pkg::hist_idx_type idx;
      for (int k = 0; k < ssmc_pkg::QUERY_MAX; k++) begin
         idx = ssmc_pkg::hist_idx_type'(int'(qlen) - 2 - k);
         b   = char_byte;
         if (int'(qlen) - 1 > k) begin
            b = hist_ff[idx];
         end
         if (k < int'(qlen)) begin
            lane_ok[k] = ssmc_pkg::fold(b, cmp_exact)
                         == ssmc_pkg::fold(query[8*k +: 8], cmp_exact);
         end else begin
            lane_ok[k] = 1'b1;
         end
      end
   end

   assign hit = &lane_ok;
endmodule

// File: hw/rtl/streaming_substring_match_collector_core.sv
// Top level of the streaming substring match collector: input stage, position
// counters, match table, navigation and result register.
// Depends on ssmc_pkg, ssmc_stream_if, ssmc_ram and ssmc_matcher.
//
//   channel   dir  handshake        payload
//   req_chan  in   valid/ready      req_type, char_byte
//   rsp_chan  out  valid/ready      result_kind .. table_full
//   csr_*     in   csr_we           csr_index, csr_wdata
//
// One transaction per cycle while the response is not stalled; a result
// passes the input register, then the result register with the table read
// beside it, from which a navigation result takes its line and column.
// Reset (synchronous) clears counters, history and both stage valid bits;
// the match table is not cleared and only entries written since a new search
// are read. A stalled response holds the result register; one further request
// waits in the input register.
module streaming_substring_match_collector_core (
   input  logic                                  clock,
   input  logic                                  reset,
   ssmc_req_if.sink                              req_chan,
   ssmc_rsp_if.source                            rsp_chan,
   input  logic                                  csr_we,
   input  logic [ssmc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ssmc_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   // configuration
   logic [ssmc_pkg::CSR_DATA_W-1:0] qlow_ff, qhigh_ff;
   ssmc_pkg::qlen_type              qlen_ff;
   logic                            cs_ff;
   ssmc_pkg::qlen_type              qlen_eff;

   // input stage
   logic                     a_valid_ff;
   ssmc_pkg::req_kind_type   a_type_ff;
   ssmc_pkg::byte_type       a_char_ff;
   logic                     a_advance;

   // search state
   ssmc_pkg::col_type        col_ff, col_in;
   ssmc_pkg::line_type       line_ff, line_in;
   ssmc_pkg::cnt_type        count_ff, count_in;
   ssmc_pkg::idx_type        cur_ff, cur_in;

   // result register
   logic                     o_valid_ff, o_valid_in;
   ssmc_pkg::result_kind_type o_kind_ff, o_kind_in;
   logic                     o_from_ram_ff, o_from_ram_in;
   ssmc_pkg::line_type       o_line_ff, o_line_in;
   ssmc_pkg::col_type        o_col_ff, o_col_in;
   ssmc_pkg::qlen_type       o_len_ff, o_len_in;
   ssmc_pkg::num_type        o_num_ff, o_num_in;
   ssmc_pkg::total_type      o_total_ff, o_total_in;
   logic                     o_full_ff, o_full_in;

   // matcher and table
   ssmc_pkg::hist_ctrl_type  hist_ctrl;
   logic                     hit;
   logic                     match_ok;
   logic                     ram_we, ram_re;
   ssmc_pkg::idx_type        ram_waddr;
   ssmc_pkg::entry_type      ram_wdata, ram_rdata;
   ssmc_pkg::cnt_type        nav_base, nav_next;
   logic                     is_text, is_nav;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         qlow_ff  <= '0;
         qhigh_ff <= '0;
         qlen_ff  <= '0;
         cs_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            ssmc_pkg::CSR_QUERY_LOW:  qlow_ff  <= csr_wdata;
            ssmc_pkg::CSR_QUERY_HIGH: qhigh_ff <= csr_wdata;
            ssmc_pkg::CSR_QUERY_LEN:  qlen_ff  <= csr_wdata[ssmc_pkg::QLEN_W-1:0];
            ssmc_pkg::CSR_CASE_SENS:  cs_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign qlen_eff = (qlen_ff > ssmc_pkg::qlen_type'(ssmc_pkg::QUERY_MAX))
                     ? ssmc_pkg::qlen_type'(ssmc_pkg::QUERY_MAX) : qlen_ff;

   // input stage: advance when the result register is free or being drained
   assign a_advance     = a_valid_ff && (!o_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !a_valid_ff || a_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         a_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         a_type_ff <= ssmc_pkg::req_kind_type'(req_chan.req_type);
         a_char_ff <= req_chan.char_byte;
      end
   end

   assign is_text = (a_type_ff == ssmc_pkg::REQ_TEXT);
   assign is_nav  = a_type_ff inside {ssmc_pkg::REQ_NEXT, ssmc_pkg::REQ_PREV};

   assign hist_ctrl.shift = a_advance && is_text;
   assign hist_ctrl.clear = a_advance && (a_type_ff == ssmc_pkg::REQ_SEARCH);

   ssmc_matcher u_matcher (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (hist_ctrl),
      .char_byte      (a_char_ff),
      .query          ({qhigh_ff, qlow_ff}),
      .qlen           (qlen_eff),
      .cmp_exact      (cs_ff),
      .hit            (hit)
   );

   assign match_ok = hit && (qlen_eff != '0)
                     && ((ssmc_pkg::col_ext_type'(col_ff) + ssmc_pkg::col_ext_type'(1))
                         >= ssmc_pkg::col_ext_type'(qlen_eff))
                     && (count_ff < ssmc_pkg::cnt_type'(ssmc_pkg::MAX_MATCHES));

   // navigation: restart from zero if the pointer lies beyond the table
   always_comb begin
      nav_base = ssmc_pkg::cnt_type'(cur_ff);
      if (nav_base >= count_ff) begin
         nav_base = '0;
      end
      if (a_type_ff == ssmc_pkg::REQ_NEXT) begin
         nav_next = (nav_base + ssmc_pkg::cnt_type'(1) == count_ff)
                    ? '0 : nav_base + ssmc_pkg::cnt_type'(1);
      end else begin
         nav_next = (nav_base == '0) ? count_ff - ssmc_pkg::cnt_type'(1)
                    : nav_base - ssmc_pkg::cnt_type'(1);
      end
   end

   assign ram_we    = a_advance && is_text && match_ok;
   assign ram_waddr = ssmc_pkg::idx_type'(count_ff);
   assign ram_wdata = {line_ff, ssmc_pkg::col_type'(col_ff + ssmc_pkg::col_type'(1)
                                                   - ssmc_pkg::col_type'(qlen_eff))};
   assign ram_re    = a_advance && is_nav && (count_ff != '0);

   ssmc_ram #(
      .WIDTH (ssmc_pkg::ENTRY_W),
      .DEPTH (ssmc_pkg::MAX_MATCHES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ssmc_pkg::idx_type'(nav_next)),
      .rdata (ram_rdata)
   );

   // state and result next values
   always_comb begin
      col_in        = col_ff;
      line_in       = line_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      o_valid_in    = o_valid_ff && !rsp_chan.ready;
      o_kind_in     = o_kind_ff;
      o_from_ram_in = o_from_ram_ff;
      o_line_in     = o_line_ff;
      o_col_in      = o_col_ff;
      o_len_in      = o_len_ff;
      o_num_in      = o_num_ff;
      o_total_in    = o_total_ff;
      o_full_in     = o_full_ff;
      if (a_advance) begin
         case (a_type_ff)
            ssmc_pkg::REQ_TEXT: begin
               if (match_ok) begin
                  count_in      = count_ff + ssmc_pkg::cnt_type'(1);
                  o_valid_in    = 1'b1;
                  o_kind_in     = ssmc_pkg::RES_NEW;
                  o_from_ram_in = 1'b0;
                  o_line_in     = ram_wdata[ssmc_pkg::ENTRY_W-1:ssmc_pkg::COL_W];
                  o_col_in      = ram_wdata[ssmc_pkg::COL_W-1:0];
                  o_len_in      = qlen_eff;
                  o_num_in      = ssmc_pkg::num_type'(count_ff);
                  o_total_in    = ssmc_pkg::total_type'(count_in);
                  o_full_in     = (count_in >= ssmc_pkg::cnt_type'(ssmc_pkg::MAX_MATCHES));
               end
               // saturate the column at the top of its range
               if (col_ff != ssmc_pkg::col_type'(ssmc_pkg::COL_MAX)) begin
                  col_in = col_ff + ssmc_pkg::col_type'(1);
               end
            end
            ssmc_pkg::REQ_EOL: begin
               if (line_ff != ssmc_pkg::line_type'(ssmc_pkg::LINE_MAX)) begin
                  line_in = line_ff + ssmc_pkg::line_type'(1);
               end
               col_in = '0;
            end
            ssmc_pkg::REQ_SEARCH: begin
               col_in   = '0;
               line_in  = '0;
               count_in = '0;
               cur_in   = '0;
            end
            ssmc_pkg::REQ_NEXT, ssmc_pkg::REQ_PREV: begin
               o_valid_in = 1'b1;
               if (count_ff == '0) begin
                  o_kind_in     = ssmc_pkg::RES_NONE;
                  o_from_ram_in = 1'b0;
                  o_line_in     = '0;
                  o_col_in      = '0;
                  o_len_in      = '0;
                  o_num_in      = '0;
                  o_total_in    = '0;
                  o_full_in     = 1'b0;
               end else begin
                  cur_in        = ssmc_pkg::idx_type'(nav_next);
                  o_kind_in     = ssmc_pkg::RES_NAV;
                  o_from_ram_in = 1'b1;
                  o_len_in      = qlen_eff;
                  o_num_in      = ssmc_pkg::num_type'(nav_next);
                  o_total_in    = ssmc_pkg::total_type'(count_ff);
                  o_full_in     = (count_ff >= ssmc_pkg::cnt_type'(ssmc_pkg::MAX_MATCHES));
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         line_ff    <= '0;
         count_ff   <= '0;
         cur_ff     <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         line_ff    <= line_in;
         count_ff   <= count_in;
         cur_ff     <= cur_in;
         o_valid_ff <= o_valid_in;
      end
      o_kind_ff     <= o_kind_in;
      o_from_ram_ff <= o_from_ram_in;
      o_line_ff     <= o_line_in;
      o_col_ff      <= o_col_in;
      o_len_ff      <= o_len_in;
      o_num_ff      <= o_num_in;
      o_total_ff    <= o_total_in;
      o_full_ff     <= o_full_in;
   end

   assign rsp_chan.valid        = o_valid_ff;
   assign rsp_chan.result_kind  = o_kind_ff;
   assign rsp_chan.line_index   = o_from_ram_ff
                                  ? ram_rdata[ssmc_pkg::ENTRY_W-1:ssmc_pkg::COL_W] : o_line_ff;
   assign rsp_chan.column       = o_from_ram_ff ? ram_rdata[ssmc_pkg::COL_W-1:0] : o_col_ff;
   assign rsp_chan.match_length = o_len_ff;
   assign rsp_chan.match_number = o_num_ff;
   assign rsp_chan.match_total  = o_total_ff;
   assign rsp_chan.table_full   = o_full_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= ssmc_pkg::cnt_type'(ssmc_pkg::MAX_MATCHES))
      else $error("match count beyond table depth");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (cur_ff == '0))
      else $error("current match set with an empty table");

   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (count_ff < ssmc_pkg::cnt_type'(ssmc_pkg::MAX_MATCHES)))
      else $error("table written while full");

   assert property (@(posedge clock) disable iff (reset)
      (a_advance && (a_type_ff == ssmc_pkg::REQ_SEARCH)) |=> (count_ff == '0 && col_ff == '0))
      else $error("new search did not clear the table");

   assert property (@(posedge clock) disable iff (reset)
      (ram_re && !ram_we) |=> (o_valid_ff && o_from_ram_ff))
      else $error("table read without a navigation result");
`endif
endmodule

// File: test/testbench.sv
// Self-checking bench for streaming_substring_match_collector_core: directed rows,
// then random query settings and text streams, and a table-full run.
// Depends on ssmc_pkg and the ssmc_req_if / ssmc_rsp_if channel interfaces.
module testbench;
   import ssmc_pkg::*;

   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 12;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int TIMEOUT_CYCLES  = 4_000_000;
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_ITEMS     = 45;
   localparam int MAX_PRINTS      = 50;

   typedef logic [REQ_W-1:0] req_code_type;

   localparam req_code_type REQ_UNUSED_LO = 3'd5;
   localparam req_code_type REQ_UNUSED_HI = 3'd7;

   localparam logic [31:0] LETTER_SET = 32'h61_62_41_42;
   localparam logic [63:0] EDGE_SET   = 64'h40_41_5A_5B_60_61_7A_7B;
   localparam logic [31:0] WIDE_SET   = 32'h00_80_7F_FF;

   typedef enum int {ALPHA_LETTERS, ALPHA_EDGES, ALPHA_WIDE} alphabet_type;
   typedef enum int {RX_STEADY, RX_COIN, RX_THIRD, RX_SPARSE} stall_mode_type;
   typedef enum logic {ROW_ITEM, ROW_REG} row_kind_type;

   typedef struct packed {
      result_kind_type kind;
      line_type        line_no;
      col_type         col;
      qlen_type        len;
      num_type         num;
      total_type       total;
      logic            full;
   } match_report_type;

   typedef struct packed {
      row_kind_type             what;
      req_code_type             req;
      byte_type                 chr;
      csr_index_type            reg_idx;
      logic [CSR_DATA_W-1:0]    reg_data;
      bit                       fixed;
      bit                       fixed_has;
      match_report_type         fixed_res;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   ssmc_req_if req_chan();
   ssmc_rsp_if rsp_chan();

   streaming_substring_match_collector_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the block: settings, byte history, counters and the match table
   query_type query_bits;
   qlen_type  query_len;
   bit        exact;
   byte_type  hist_bytes [HIST_DEPTH];
   col_type   col_count;
   line_type  cur_line;
   line_type  hit_line [MAX_MATCHES];
   col_type   hit_col [MAX_MATCHES];
   cnt_type   found_count;
   idx_type   cursor;

   match_report_type expected_reports[$];
   match_report_type oldest_report;
   stim_row_type     directed_rows[$];
   int               mismatch_count = 0;
   int               burst_left = 0;
   bit               hold_off_pending = 1'b0;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic byte_type canon(input byte_type b);
      if (!exact && b >= 8'h41 && b <= 8'h5A) begin
         return b | 8'h20;
      end
      return b;
   endfunction

   function automatic int active_len();
      return (int'(query_len) > QUERY_MAX) ? QUERY_MAX : int'(query_len);
   endfunction

   // Advance the shadow by one item; return 1 with the report where the item yields one
   function automatic bit search_step(input req_code_type r, input byte_type c,
                                      output match_report_type res);
      int  eff;
      int  k;
      int  pick;
      bit  hit;
      byte_type window_byte;
      res = '0;
      eff = active_len();
      case (r)
         REQ_TEXT: begin
            hit = 1'b0;
            if (eff > 0 && int'(col_count) + 1 >= eff && int'(found_count) < MAX_MATCHES) begin
               hit = 1'b1;
               for (k = 0; k < eff; k++) begin
                  window_byte = (k == eff - 1) ? c : hist_bytes[eff - 2 - k];
                  if (canon(window_byte) != canon(query_bits[8*k +: 8])) begin
                     hit = 1'b0;
                  end
               end
            end
            if (hit) begin
               hit_line[idx_type'(found_count)] = cur_line;
               hit_col[idx_type'(found_count)]  = col_type'(int'(col_count) + 1 - eff);
               res.kind    = RES_NEW;
               res.line_no = cur_line;
               res.col     = hit_col[idx_type'(found_count)];
               res.len     = qlen_type'(eff);
               res.num     = num_type'(found_count);
               found_count = found_count + cnt_type'(1);
               res.total   = total_type'(found_count);
               res.full    = (int'(found_count) >= MAX_MATCHES);
            end
            for (k = HIST_DEPTH - 1; k > 0; k--) begin
               hist_bytes[k] = hist_bytes[k - 1];
            end
            hist_bytes[0] = c;
            if (int'(col_count) < COL_MAX) begin
               col_count = col_count + col_type'(1);
            end
            return hit;
         end
         REQ_EOL: begin
            if (int'(cur_line) < LINE_MAX) begin
               cur_line = cur_line + line_type'(1);
            end
            col_count = '0;
            return 1'b0;
         end
         REQ_SEARCH: begin
            for (k = 0; k < HIST_DEPTH; k++) begin
               hist_bytes[k] = '0;
            end
            col_count   = '0;
            cur_line    = '0;
            found_count = '0;
            cursor      = '0;
            return 1'b0;
         end
         REQ_NEXT, REQ_PREV: begin
            if (found_count == 0) begin
               res.kind = RES_NONE;
               return 1'b1;
            end
            if (int'(cursor) >= int'(found_count)) begin
               cursor = '0;
            end
            if (r == REQ_NEXT) begin
               pick = (int'(cursor) + 1) % int'(found_count);
            end else begin
               pick = (int'(cursor) + int'(found_count) - 1) % int'(found_count);
            end
            cursor      = idx_type'(pick);
            res.kind    = RES_NAV;
            res.line_no = hit_line[idx_type'(pick)];
            res.col     = hit_col[idx_type'(pick)];
            res.len     = qlen_type'(eff);
            res.num     = num_type'(pick);
            res.total   = total_type'(found_count);
            res.full    = (int'(found_count) >= MAX_MATCHES);
            return 1'b1;
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   function automatic match_report_type make_report(input result_kind_type kind, input int ln,
                                                     input int col, input int len, input int num,
                                                     input int total, input bit full);
      match_report_type r;
      r.kind    = kind;
      r.line_no = line_type'(ln);
      r.col     = col_type'(col);
      r.len     = qlen_type'(len);
      r.num     = num_type'(num);
      r.total   = total_type'(total);
      r.full    = full;
      return r;
   endfunction

   function automatic byte_type pool_byte(input alphabet_type a);
      int pick;
      case (a)
         ALPHA_LETTERS: begin
            pick = $urandom_range(0, 3);
            return LETTER_SET[8*pick +: 8];
         end
         ALPHA_EDGES: begin
            pick = $urandom_range(0, 7);
            return EDGE_SET[8*pick +: 8];
         end
         default: begin
            pick = $urandom_range(0, 3);
            return WIDE_SET[8*pick +: 8];
         end
      endcase
   endfunction

   function automatic void add_item(input req_code_type r, input byte_type c);
      stim_row_type row;
      row = '0;
      row.what = ROW_ITEM;
      row.req  = r;
      row.chr  = c;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_fixed(input req_code_type r, input byte_type c,
                                     input bit has, input match_report_type res);
      stim_row_type row;
      row = '0;
      row.what      = ROW_ITEM;
      row.req       = r;
      row.chr       = c;
      row.fixed     = 1'b1;
      row.fixed_has = has;
      row.fixed_res = res;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] d);
      stim_row_type row;
      row = '0;
      row.what     = ROW_REG;
      row.reg_idx  = idx;
      row.reg_data = d;
      directed_rows.push_back(row);
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
   endtask

   // Offer one transaction, hold it until taken, then predict its outcome
   task automatic send_item(input req_code_type r, input byte_type c,
                            input bit fixed = 1'b0, input bit fixed_has = 1'b0,
                            input match_report_type fixed_res = '0);
      match_report_type predicted;
      bit produced;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_chan.valid     <= 1'b1;
      req_chan.req_type  <= r;
      req_chan.char_byte <= c;
      do @(posedge clock); while (!req_chan.ready);
      produced = search_step(r, c, predicted);
      if (fixed) begin
         if (fixed_has) begin
            expected_reports.push_back(fixed_res);
         end
      end else if (produced) begin
         expected_reports.push_back(predicted);
      end
   endtask

   // Drop valid and wait until every outstanding result has been taken
   task automatic wait_drained();
      int guard;
      req_chan.valid <= 1'b0;
      for (guard = 0; guard < DRAIN_LIMIT && expected_reports.size() != 0; guard++) begin
         @(posedge clock);
      end
      if (expected_reports.size() != 0) begin
         flag_mismatch($sformatf("%0d results never arrived", expected_reports.size()));
         expected_reports.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] d);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_QUERY_LOW:  query_bits[CSR_DATA_W-1:0] = d;
         CSR_QUERY_HIGH: query_bits[QUERY_W-1:CSR_DATA_W] = d;
         CSR_QUERY_LEN:  query_len = d[QLEN_W-1:0];
         CSR_CASE_SENS:  exact = d[0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input query_type q, input int len, input bit ex);
      logic [CSR_DATA_W-1:0] filler;
      filler = {$urandom, $urandom};
      write_reg(CSR_QUERY_LOW, q[CSR_DATA_W-1:0]);
      write_reg(CSR_QUERY_HIGH, q[QUERY_W-1:CSR_DATA_W]);
      write_reg(CSR_QUERY_LEN, {filler[CSR_DATA_W-1:QLEN_W], qlen_type'(len)});
      write_reg(CSR_CASE_SENS, {filler[CSR_DATA_W-1:1], ex});
   endtask

   // Result side: stall on a pattern of its own, with an occasional long hold-off
   initial begin
      stall_mode_type mode;
      int span;
      int n;
      rsp_chan.ready <= 1'b0;
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            for (n = 0; n < HOLD_OFF_CYCLES; n++) begin
               @(posedge clock);
               rsp_chan.ready <= 1'b0;
            end
         end
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(10, 80);
         for (n = 0; n < span && !hold_off_pending; n++) begin
            @(posedge clock);
            case (mode)
               RX_STEADY: rsp_chan.ready <= 1'b1;
               RX_COIN:   rsp_chan.ready <= 1'($urandom_range(0, 1));
               RX_THIRD:  rsp_chan.ready <= (n % 3 == 0);
               default:   rsp_chan.ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_reports.size() == 0) begin
            flag_mismatch($sformatf("unexpected result kind %0d line %0d col %0d num %0d",
                                    rsp_chan.result_kind, rsp_chan.line_index,
                                    rsp_chan.column, rsp_chan.match_number));
         end else begin
            oldest_report = expected_reports.pop_front();
            if (rsp_chan.result_kind !== oldest_report.kind ||
                rsp_chan.line_index !== oldest_report.line_no ||
                rsp_chan.column !== oldest_report.col ||
                rsp_chan.match_length !== oldest_report.len ||
                rsp_chan.match_number !== oldest_report.num ||
                rsp_chan.match_total !== oldest_report.total ||
                rsp_chan.table_full !== oldest_report.full) begin
               flag_mismatch($sformatf(
                  "got %0d/%0d/%0d/%0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                  rsp_chan.result_kind, rsp_chan.line_index, rsp_chan.column,
                  rsp_chan.match_length, rsp_chan.match_number, rsp_chan.match_total,
                  rsp_chan.table_full, oldest_report.kind, oldest_report.line_no,
                  oldest_report.col, oldest_report.len, oldest_report.num,
                  oldest_report.total, oldest_report.full));
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      stim_row_type row;
      query_type    q_word;
      alphabet_type alpha;
      byte_type     c;
      int           q_len;
      int           eff;
      int           phase;
      int           sent;
      int           pick;
      int           i;
      int           k;
      bit           ex;

      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      req_chan.valid     <= 1'b0;
      req_chan.req_type  <= '0;
      req_chan.char_byte <= '0;

      query_bits  = '0;
      query_len   = '0;
      exact       = 1'b0;
      col_count   = '0;
      cur_line    = '0;
      found_count = '0;
      cursor      = '0;
      for (k = 0; k < HIST_DEPTH; k++) begin
         hist_bytes[k] = '0;
      end

      // Empty table, zero query length and ignored request codes straight after reset
      add_fixed(REQ_NEXT, 8'h00, 1'b1, make_report(RES_NONE, 0, 0, 0, 0, 0, 1'b0));
      add_fixed(REQ_PREV, 8'hFF, 1'b1, make_report(RES_NONE, 0, 0, 0, 0, 0, 1'b0));
      add_fixed(REQ_TEXT, 8'h00, 1'b0, '0);
      add_fixed(REQ_TEXT, 8'hFF, 1'b0, '0);
      add_fixed(REQ_UNUSED_LO, 8'h55, 1'b0, '0);
      add_fixed(REQ_UNUSED_HI, 8'hAA, 1'b0, '0);
      // Query "aB", folded; bytes above the length are junk
      add_reg(CSR_QUERY_LOW, 64'hFFFF_FFFF_FFFF_4261);
      add_reg(CSR_QUERY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      add_reg(CSR_QUERY_LEN, 64'd2);
      add_reg(CSR_CASE_SENS, 64'd0);
      add_fixed(REQ_SEARCH, 8'h00, 1'b0, '0);
      add_fixed(REQ_TEXT, "A", 1'b0, '0);
      add_fixed(REQ_TEXT, "b", 1'b1, make_report(RES_NEW, 0, 0, 2, 0, 1, 1'b0));
      add_item(REQ_TEXT, "a");
      add_item(REQ_TEXT, "B");
      add_item(REQ_EOL, 8'h00);
      add_item(REQ_TEXT, "B");
      add_item(REQ_NEXT, 8'h00);
      add_item(REQ_NEXT, 8'h00);
      add_item(REQ_PREV, 8'h00);
      // Same query compared exactly
      add_reg(CSR_CASE_SENS, 64'd1);
      add_item(REQ_TEXT, "a");
      add_item(REQ_TEXT, "B");
      add_item(REQ_TEXT, "A");
      add_item(REQ_TEXT, "b");

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < directed_rows.size(); i++) begin
         row = directed_rows[i];
         if (row.what == ROW_REG) begin
            wait_drained();
            write_reg(row.reg_idx, row.reg_data);
         end else begin
            send_item(row.req, row.chr, row.fixed, row.fixed_has, row.fixed_res);
         end
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         ex    = bit'($urandom_range(0, 1));
         alpha = alphabet_type'($urandom_range(0, 2));
         case (phase)
            0: begin
               q_len = 31;
               ex    = 1'b1;
               alpha = ALPHA_WIDE;
            end
            1:       q_len = 0;
            2:       q_len = QUERY_MAX;
            default: begin
               pick = $urandom_range(0, 9);
               if (pick == 0)      q_len = 0;
               else if (pick < 5)  q_len = $urandom_range(1, 3);
               else if (pick < 7)  q_len = $urandom_range(4, 15);
               else if (pick == 7) q_len = QUERY_MAX;
               else if (pick == 8) q_len = $urandom_range(QUERY_MAX + 1, 31);
               else                q_len = $urandom_range(1, 2);
            end
         endcase
         eff = (q_len > QUERY_MAX) ? QUERY_MAX : q_len;
         for (k = 0; k < QUERY_MAX; k++) begin
            q_word[8*k +: 8] = (k < eff) ? pool_byte(alpha) : byte_type'($urandom_range(0, 255));
         end
         if (phase == 0) begin
            q_word = '1;
         end else if (phase == 1) begin
            q_word = '0;
         end
         wait_drained();
         load_settings(q_word, q_len, ex);
         if (phase == 3 || phase == 8) begin
            hold_off_pending = 1'b1;
         end
         if ($urandom_range(0, 1)) begin
            send_item(REQ_SEARCH, byte_type'($urandom_range(0, 255)));
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
               send_item($urandom_range(0, 1) ? REQ_NEXT : REQ_PREV,
                         byte_type'($urandom_range(0, 255)));
               sent++;
            end else if (pick < 10) begin
               send_item(REQ_EOL, byte_type'($urandom_range(0, 255)));
               sent++;
            end else if (pick < 11) begin
               send_item(REQ_SEARCH, byte_type'($urandom_range(0, 255)));
               sent++;
            end else if (pick < 12) begin
               send_item(req_code_type'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)),
                         byte_type'($urandom_range(0, 255)));
            end else if (pick < 20) begin
               // Plant a copy of the query, flipping letter case where folding applies
               for (k = 0; k < eff; k++) begin
                  c = q_word[8*k +: 8];
                  if (!ex && (c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A &&
                      $urandom_range(0, 1)) begin
                     c = c ^ 8'h20;
                  end
                  send_item(REQ_TEXT, c);
               end
               sent += eff;
            end else begin
               c = ($urandom_range(0, 6) == 0) ? byte_type'($urandom_range(0, 255))
                                               : pool_byte(alpha);
               send_item(REQ_TEXT, c);
               sent++;
            end
         end
      end

      // Fill the table with single-letter hits, overrun it, then wrap the cursor
      wait_drained();
      q_word = {$urandom, $urandom, $urandom, $urandom};
      q_word[7:0] = "e";
      load_settings(q_word, 1, 1'b0);
      send_item(REQ_SEARCH, 8'h00);
      for (i = 0; i < MAX_MATCHES + 44; i++) begin
         send_item(REQ_TEXT, $urandom_range(0, 1) ? "e" : "E");
      end
      send_item(REQ_PREV, 8'h00);
      send_item(REQ_PREV, 8'h00);
      send_item(REQ_NEXT, 8'h00);
      send_item(REQ_NEXT, 8'h00);
      send_item(REQ_NEXT, 8'h00);

      wait_drained();
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
